FILE: rtl/learned_transition_sampler_defines.svh
// Assertion macros shared by the checker of the learned transition sampler.
// Needs a clk and an arst_n signal in the scope where a macro is used.
`ifndef LEARNED_TRANSITION_SAMPLER_DEFINES_SVH
`define LEARNED_TRANSITION_SAMPLER_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define LTS_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("lts check failed");

// Consequent checked in the cycle after the antecedent.
`define LTS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("lts check failed");

`endif

FILE: rtl/lts_pkg.sv
// Package of the learned transition sampler: codes, widths, sequencer states.
// No dependencies.
package lts_pkg;
	localparam int N_W        = 5;
	localparam int IDX_W      = 4;
	localparam int WORD_W     = 16;
	localparam int PROB_W     = 17;
	localparam int WEIGHT_W   = 40;
	localparam int CFG_ADDR_W = 2;
	localparam int CFG_DATA_W = 16;
	localparam int INIT_WEIGHT_PER_CHOICE = 20;

	typedef enum logic [1:0] {
		REQ_DRAW   = 2'd0,
		REQ_UPDATE = 2'd1,
		REQ_CLEAR  = 2'd2,
		REQ_NONE   = 2'd3
	} req_type_t;

	typedef enum logic [CFG_ADDR_W-1:0] {
		CFG_NUM_CHOICES       = 2'd0,
		CFG_EXPLORE_THRESHOLD = 2'd1
	} cfg_addr_t;

	typedef enum logic [4:0] {
		ST_INIT, ST_IDLE,
		ST_D_RD, ST_D_CHK, ST_D_EXP, ST_D_CRD, ST_D_CWR,
		ST_U_ROW, ST_U_RD, ST_U_M1, ST_U_M2, ST_U_ACC, ST_U_WT,
		ST_U_DSET, ST_U_DIV, ST_U_WR, ST_U_CLR,
		ST_C_SWEEP, ST_DONE
	} state_t;

	// Uniform probability floor(65536 / n) for n from 1 to 16.
	function automatic logic [PROB_W-1:0] uniform_prob(input logic [N_W-1:0] n);
		logic [PROB_W-1:0] p;
		case (n)
			5'd1:    p = 17'd65536;
			5'd2:    p = 17'd32768;
			5'd3:    p = 17'd21845;
			5'd4:    p = 17'd16384;
			5'd5:    p = 17'd13107;
			5'd6:    p = 17'd10922;
			5'd7:    p = 17'd9362;
			5'd8:    p = 17'd8192;
			5'd9:    p = 17'd7281;
			5'd10:   p = 17'd6553;
			5'd11:   p = 17'd5957;
			5'd12:   p = 17'd5461;
			5'd13:   p = 17'd5041;
			5'd14:   p = 17'd4681;
			5'd15:   p = 17'd4369;
			default: p = 17'd4096;
		endcase
		return p;
	endfunction
endpackage

FILE: rtl/lts_req_if.sv
// Request channel of the learned transition sampler.
// Depends on lts_pkg.
interface lts_req_if;
	import lts_pkg::*;
	logic              valid;
	logic              ready;
	logic [1:0]        req_type;
	logic [IDX_W-1:0]  current_index;
	logic [WORD_W-1:0] rand_choose;
	logic [WORD_W-1:0] rand_pick;
	modport source (output valid, req_type, current_index, rand_choose, rand_pick,
		input ready);
	modport sink (input valid, req_type, current_index, rand_choose, rand_pick,
		output ready);
endinterface

FILE: rtl/lts_rsp_if.sv
// Result channel of the learned transition sampler.
// Depends on lts_pkg.
interface lts_rsp_if;
	import lts_pkg::*;
	logic             valid;
	logic             ready;
	logic [IDX_W-1:0] selected_index;
	logic             explored;
	modport source (output valid, selected_index, explored, input ready);
	modport sink (input valid, selected_index, explored, output ready);
endinterface

FILE: rtl/lts_cfg_if.sv
// Configuration write channel of the learned transition sampler.
// Depends on lts_pkg.
interface lts_cfg_if;
	import lts_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_ADDR_W-1:0] addr;
	logic [CFG_DATA_W-1:0] data;
	modport source (output valid, addr, data, input ready);
	modport sink (input valid, addr, data, output ready);
endinterface

FILE: rtl/learned_transition_sampler.sv
// Learned transition sampler.
// Channels: req (request items), rsp (one result item per request), cfg (register writes,
// always ready; write only while idle). Register 0 is num_choices, register 1 the
// exploration threshold.
// After reset a clearing pass writes NLIMIT*NLIMIT table cells, one per cycle, with
// NLIMIT = min(MAX_CHOICES, 16); req.ready stays low during it.
// A roulette draw reads one row cell by cell through the registered RAM port until the
// running sum passes the pick or the last column is reached; exploring reads none.
// An update runs every active cell of every active row twice through one shared
// 17x20 multiplier and, on the second pass, through a one-bit-per-cycle divider,
// which sets the pace; afterwards every count cell of the table is cleared.
// A clear rewrites every table cell; an out-of-range draw or unused code does no work.
// One item is worked on at a time. The finished result sits in an output register, and
// a new item is accepted while it waits; if the receiver stalls, the next finished
// result waits inside the block until the register frees up.
module learned_transition_sampler #(
	parameter int MAX_CHOICES = 16
) (
	input logic       clk,
	input logic       arst_n,
	lts_req_if.sink   req,
	lts_rsp_if.source rsp,
	lts_cfg_if.sink   cfg
);
	import lts_pkg::*;

	localparam int NLIMIT = (MAX_CHOICES < 16) ? MAX_CHOICES : 16;
	localparam int IW     = $clog2(MAX_CHOICES);
	localparam int AW     = 2 * IW;
	localparam int DEPTH  = 1 << AW;
	localparam int RW_W   = $clog2(NLIMIT);

	state_t state_q, state_d;

	logic [N_W-1:0]      num_choices_q;
	logic [WORD_W-1:0]   thresh_q;
	logic [N_W-1:0]      n_eff;
	logic [N_W-1:0]      n_last;

	logic [IDX_W-1:0]    idx_q;
	logic [WORD_W-1:0]   pick_q;

	logic [N_W-1:0]      row_q, col_q;
	logic [20:0]         acc_q;
	logic [IDX_W-1:0]    sel_q;
	logic                expl_q;
	logic [PROB_W-1:0]   p_q;
	logic [WORD_W-1:0]   cnt_q;
	logic [36:0]         lo_q;
	logic [41:0]         v_q;
	logic [45:0]         s_q;
	logic [19:0]         t_q;
	logic [WEIGHT_W-1:0] w_q;
	logic [45:0]         rem_q;
	logic [PROB_W-1:0]   quot_q;
	logic [3:0]          step_q;
	logic                pass_q;
	logic [PROB_W-1:0]   fill_q;
	logic [WEIGHT_W-1:0] rw_q [NLIMIT];

	logic                out_valid_q;
	logic [IDX_W-1:0]    out_sel_q;
	logic                out_expl_q;

	logic [AW-1:0]       raddr, waddr;
	logic                prob_we, cnt_we;
	logic [PROB_W-1:0]   prob_wdata, prob_rdata;
	logic [WORD_W-1:0]   cnt_wdata, cnt_rdata;

	logic [PROB_W-1:0]   mul_a;
	logic [19:0]         mul_b;
	logic [36:0]         prod;
	logic [56:0]         full;
	logic [20:0]         acc_next;
	logic [46:0]         rem_sh;
	logic [45:0]         v_ext;
	logic [40:0]         w_sum;
	logic                last_col, sweep_last, accept, load_out;

	// Effective choice count, saturated to 1..NLIMIT.
	always_comb begin
		if (num_choices_q == '0) begin
			n_eff = N_W'(1);
		end else if (num_choices_q > N_W'(NLIMIT)) begin
			n_eff = N_W'(NLIMIT);
		end else begin
			n_eff = num_choices_q;
		end
	end

	assign n_last     = n_eff - N_W'(1);
	assign last_col   = (col_q == n_last);
	assign sweep_last = (row_q == N_W'(NLIMIT - 1)) && (col_q == N_W'(NLIMIT - 1));
	assign accept     = req.valid && req.ready;
	assign load_out   = (state_q == ST_DONE) && (!out_valid_q || rsp.ready);

	assign prod     = 37'(mul_a) * 37'(mul_b);
	assign full     = {prod, 20'b0} + 57'(lo_q);
	assign acc_next = acc_q + 21'(prob_rdata);
	assign rem_sh   = {rem_q, 1'b0};
	assign v_ext    = 46'(v_q);
	assign w_sum    = 41'(w_q) + 41'(t_q);

	assign req.ready          = (state_q == ST_IDLE);
	assign cfg.ready          = 1'b1;
	assign rsp.valid          = out_valid_q;
	assign rsp.selected_index = out_sel_q;
	assign rsp.explored       = out_expl_q;

	lts_ram #(.W(PROB_W), .DEPTH(DEPTH)) u_prob_ram (
		.clk   (clk),
		.we    (prob_we),
		.waddr (waddr),
		.wdata (prob_wdata),
		.raddr (raddr),
		.rdata (prob_rdata)
	);

	lts_ram #(.W(WORD_W), .DEPTH(DEPTH)) u_cnt_ram (
		.clk   (clk),
		.we    (cnt_we),
		.waddr (waddr),
		.wdata (cnt_wdata),
		.raddr (raddr),
		.rdata (cnt_rdata)
	);

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_INIT: begin
				if (sweep_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (accept) begin
					case (req.req_type)
						REQ_DRAW: begin
							if (N_W'(req.current_index) >= n_eff) begin
								state_d = ST_DONE;
							end else if (req.rand_choose <= thresh_q) begin
								state_d = ST_D_EXP;
							end else begin
								state_d = ST_D_RD;
							end
						end
						REQ_UPDATE: state_d = ST_U_ROW;
						REQ_CLEAR:  state_d = ST_C_SWEEP;
						default:    state_d = ST_DONE;
					endcase
				end
			end
			ST_D_RD:  state_d = ST_D_CHK;
			ST_D_CHK: begin
				if ((21'(pick_q) < acc_next) || last_col) begin
					state_d = ST_D_CRD;
				end else begin
					state_d = ST_D_RD;
				end
			end
			ST_D_EXP: state_d = ST_D_CRD;
			ST_D_CRD: state_d = ST_D_CWR;
			ST_D_CWR: state_d = ST_DONE;
			ST_U_ROW: state_d = (row_q == n_eff) ? ST_U_CLR : ST_U_RD;
			ST_U_RD:  state_d = ST_U_M1;
			ST_U_M1:  state_d = ST_U_M2;
			ST_U_M2:  state_d = pass_q ? ST_U_DSET : ST_U_ACC;
			ST_U_ACC: state_d = last_col ? ST_U_WT : ST_U_RD;
			ST_U_WT:  state_d = ST_U_RD;
			ST_U_DSET: state_d = (s_q == '0) ? ST_U_WR : ST_U_DIV;
			ST_U_DIV: begin
				if (step_q == 4'd15) state_d = ST_U_WR;
			end
			ST_U_WR:  state_d = last_col ? ST_U_ROW : ST_U_RD;
			ST_U_CLR: begin
				if (sweep_last) state_d = ST_DONE;
			end
			ST_C_SWEEP: begin
				if (sweep_last) state_d = ST_DONE;
			end
			ST_DONE: begin
				if (load_out) state_d = ST_IDLE;
			end
			default: state_d = ST_INIT;
		endcase
	end

	// Memory controls and multiplier operands.
	always_comb begin
		raddr      = '0;
		waddr      = {IW'(row_q), IW'(col_q)};
		prob_we    = 1'b0;
		cnt_we     = 1'b0;
		prob_wdata = fill_q;
		cnt_wdata  = '0;
		mul_a      = prob_rdata;
		mul_b      = w_q[19:0];
		case (state_q)
			ST_INIT, ST_C_SWEEP: begin
				prob_we = 1'b1;
				cnt_we  = 1'b1;
			end
			ST_D_RD:  raddr = {IW'(idx_q), IW'(col_q)};
			ST_D_EXP: begin
				mul_a = PROB_W'(pick_q);
				mul_b = 20'(n_eff);
			end
			ST_D_CRD: raddr = {IW'(idx_q), IW'(sel_q)};
			ST_D_CWR: begin
				waddr     = {IW'(idx_q), IW'(sel_q)};
				cnt_we    = (cnt_rdata != '1);
				cnt_wdata = cnt_rdata + WORD_W'(1);
			end
			ST_U_RD:  raddr = {IW'(row_q), IW'(col_q)};
			ST_U_M2: begin
				mul_a = p_q;
				mul_b = w_q[39:20];
			end
			ST_U_WR: begin
				prob_we    = 1'b1;
				prob_wdata = quot_q;
			end
			ST_U_CLR: cnt_we = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_INIT;
			num_choices_q <= N_W'(16);
			thresh_q      <= WORD_W'(16384);
			row_q         <= '0;
			col_q         <= '0;
			fill_q        <= uniform_prob(N_W'(NLIMIT));
			out_valid_q   <= 1'b0;
			for (int i = 0; i < NLIMIT; i++) begin
				rw_q[i] <= WEIGHT_W'(NLIMIT * INIT_WEIGHT_PER_CHOICE);
			end
		end else begin
			state_q <= state_d;

			if (cfg.valid) begin
				case (cfg.addr)
					CFG_NUM_CHOICES:       num_choices_q <= cfg.data[N_W-1:0];
					CFG_EXPLORE_THRESHOLD: thresh_q <= cfg.data[WORD_W-1:0];
					default: ;
				endcase
			end

			if (load_out) begin
				out_valid_q <= 1'b1;
				out_sel_q   <= sel_q;
				out_expl_q  <= expl_q;
			end else if (rsp.valid && rsp.ready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_INIT, ST_C_SWEEP, ST_U_CLR: begin
					if (col_q == N_W'(NLIMIT - 1)) begin
						col_q <= '0;
						row_q <= sweep_last ? '0 : row_q + N_W'(1);
					end else begin
						col_q <= col_q + N_W'(1);
					end
				end
				ST_IDLE: begin
					idx_q    <= req.current_index;
					pick_q   <= req.rand_pick;
					sel_q    <= '0;
					expl_q   <= 1'b0;
					acc_q    <= '0;
					row_q    <= '0;
					col_q    <= '0;
					if (accept && req.req_type == REQ_CLEAR) begin
						fill_q <= uniform_prob(n_eff);
						for (int i = 0; i < NLIMIT; i++) begin
							rw_q[i] <= WEIGHT_W'(n_eff) * WEIGHT_W'(INIT_WEIGHT_PER_CHOICE);
						end
					end
				end
				ST_D_CHK: begin
					if (21'(pick_q) < acc_next) begin
						sel_q <= IDX_W'(col_q);
					end else if (last_col) begin
						sel_q <= IDX_W'(n_last);
					end else begin
						col_q <= col_q + N_W'(1);
						acc_q <= acc_next;
					end
				end
				ST_D_EXP: begin
					sel_q  <= prod[19:16];
					expl_q <= 1'b1;
				end
				ST_U_ROW: begin
					s_q    <= '0;
					t_q    <= '0;
					pass_q <= 1'b0;
					col_q  <= '0;
					if (row_q != n_eff) begin
						w_q <= rw_q[row_q[RW_W-1:0]];
					end else begin
						row_q <= '0;
					end
				end
				ST_U_M1: begin
					p_q   <= prob_rdata;
					cnt_q <= cnt_rdata;
					lo_q  <= prod;
				end
				ST_U_M2: begin
					v_q <= 42'(full[56:16]) + 42'(cnt_q);
				end
				ST_U_ACC: begin
					s_q <= s_q + v_ext;
					t_q <= t_q + 20'(cnt_q);
					if (!last_col) col_q <= col_q + N_W'(1);
				end
				ST_U_WT: begin
					// The weight used for the row stays in w_q for the second pass.
					rw_q[row_q[RW_W-1:0]] <= w_sum[40] ? '1 : w_sum[WEIGHT_W-1:0];
					pass_q <= 1'b1;
					col_q  <= '0;
				end
				ST_U_DSET: begin
					step_q <= '0;
					if (s_q == '0) begin
						quot_q <= uniform_prob(n_eff);
					end else if (v_ext >= s_q) begin
						// The cell holds the whole row sum, so the quotient is 1.0.
						rem_q  <= v_ext - s_q;
						quot_q <= PROB_W'(1);
					end else begin
						rem_q  <= v_ext;
						quot_q <= '0;
					end
				end
				ST_U_DIV: begin
					step_q <= step_q + 4'd1;
					if (rem_sh >= 47'(s_q)) begin
						rem_q  <= 46'(rem_sh - 47'(s_q));
						quot_q <= {quot_q[PROB_W-2:0], 1'b1};
					end else begin
						rem_q  <= rem_sh[45:0];
						quot_q <= {quot_q[PROB_W-2:0], 1'b0};
					end
				end
				ST_U_WR: begin
					if (last_col) begin
						row_q <= row_q + N_W'(1);
					end else begin
						col_q <= col_q + N_W'(1);
					end
				end
				default: ;
			endcase
		end
	end
endmodule

FILE: rtl/lts_ram.sv
// Generic single write, single read RAM with registered read data.
// No dependencies.
module lts_ram #(
	parameter int W     = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [W-1:0]             wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [W-1:0]             rdata
);
	logic [W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

FILE: rtl/lts_chk.sv
// Port-level checker of the learned transition sampler, bound to its top level.
// Depends on learned_transition_sampler_defines.svh.
`include "learned_transition_sampler_defines.svh"

module lts_chk (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_ready,
	input logic rsp_valid,
	input logic rsp_ready
);
	// One item at a time: the block is busy right after it takes one.
	`LTS_ASSERT_NEXT(a_busy_after_accept, req_valid && req_ready, !req_ready)
	// A new result only comes out of a busy cycle.
	`LTS_ASSERT_NOW(a_result_after_work, $rose(rsp_valid), $past(!req_ready))
	`LTS_ASSERT_NEXT(a_rsp_held, rsp_valid && !rsp_ready, rsp_valid)
endmodule

bind learned_transition_sampler lts_chk u_lts_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req.valid),
	.req_ready (req.ready),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready)
);

FILE: tb/learned_transition_sampler_test.sv
// Testbench of the learned transition sampler: random and directed requests, with a
// built-in prediction of the probability, count and weight tables and an in-order check.
// Depends on lts_pkg, the lts_req_if, lts_rsp_if and lts_cfg_if interfaces and learned_transition_sampler.
module learned_transition_sampler_test;
	timeunit 1ns;
	timeprecision 1ps;
	import lts_pkg::*;

	localparam int NCH = 16;
	localparam int CYCLE_LIMIT = 4000000;

	typedef struct packed {
		req_type_t         kind;
		logic [IDX_W-1:0]  row;
		logic [WORD_W-1:0] choose;
		logic [WORD_W-1:0] pick;
	} request_t;

	typedef struct packed {
		logic [IDX_W-1:0] sel;
		logic             expl;
	} pick_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	lts_req_if rq();
	lts_rsp_if rs();
	lts_cfg_if cf();

	learned_transition_sampler #(.MAX_CHOICES(NCH)) u_dut (
		.clk(clk), .arst_n(arst_n), .req(rq.sink), .rsp(rs.source), .cfg(cf.sink)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Mirror of the block's state.
	logic [PROB_W-1:0]   prob_tab [NCH*NCH];
	logic [WORD_W-1:0]   hit_tab [NCH*NCH];
	logic [WEIGHT_W-1:0] row_wt [NCH];
	logic [4:0]          n_reg;
	logic [WORD_W-1:0]   thr_reg;

	request_t pending_reqs[$];
	pick_t    expected_picks[$];
	int       errors = 0;
	int       cycles = 0;
	int       hold_cnt = 0;
	bit       no_gaps = 0;
	bit       req_taken = 0;
	int       req_gap = 0;
	int       rsp_gap = 0;

	function automatic int active_n();
		int n;
		n = n_reg;
		if (n < 1) n = 1;
		if (n > NCH) n = NCH;
		return n;
	endfunction

	task automatic restore_uniform();
		int n;
		n = active_n();
		for (int i = 0; i < NCH*NCH; i++) begin
			prob_tab[i] = 17'(65536 / n);
			hit_tab[i] = '0;
		end
		for (int i = 0; i < NCH; i++) row_wt[i] = 40'(n * INIT_WEIGHT_PER_CHOICE);
	endtask

	task automatic fold_hits();
		int n;
		longint unsigned w, t, s;
		longint unsigned cellv [NCH];
		n = active_n();
		for (int r = 0; r < n; r++) begin
			w = row_wt[r];
			t = 0;
			s = 0;
			for (int c = 0; c < n; c++) begin
				cellv[c] = ((longint'(prob_tab[r*NCH+c]) * w) >> 16) + hit_tab[r*NCH+c];
				s += cellv[c];
				t += hit_tab[r*NCH+c];
			end
			w += t;
			if (w > 64'hFF_FFFF_FFFF) w = 64'hFF_FFFF_FFFF;
			row_wt[r] = w[WEIGHT_W-1:0];
			for (int c = 0; c < n; c++)
				prob_tab[r*NCH+c] = (s == 0) ? 17'(65536 / n) : 17'((cellv[c] << 16) / s);
		end
		for (int i = 0; i < NCH*NCH; i++) hit_tab[i] = '0;
	endtask

	task automatic predict_pick(input request_t it, output pick_t res);
		int n, base;
		int unsigned acc;
		n = active_n();
		res = '0;
		case (it.kind)
			REQ_DRAW: begin
				if (it.row < n) begin
					base = it.row * NCH;
					if (it.choose <= thr_reg) begin
						res.expl = 1'b1;
						res.sel = 4'((int'(it.pick) * n) >> 16);
					end else begin
						acc = 0;
						res.sel = 4'(n - 1);
						for (int c = 0; c < n; c++) begin
							acc += prob_tab[base+c];
							if (it.pick < acc) begin
								res.sel = 4'(c);
								break;
							end
						end
					end
					if (hit_tab[base+res.sel] != 16'hFFFF)
						hit_tab[base+res.sel] = hit_tab[base+res.sel] + 1;
				end
			end
			REQ_UPDATE: fold_hits();
			REQ_CLEAR: restore_uniform();
			default: ;
		endcase
	endtask

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("mismatch %s: got %0d, expected %0d", what, got, want);
		errors++;
	endtask

	task automatic add_req(input request_t it);
		pending_reqs = {pending_reqs, it};
	endtask

	// Request driver: items change at the falling edge, acceptance is seen at the rising edge.
	always @(posedge clk) begin
		request_t it;
		pick_t res;
		if (rq.valid && rq.ready) begin
			it = '{kind: req_type_t'(rq.req_type), row: rq.current_index,
				choose: rq.rand_choose, pick: rq.rand_pick};
			predict_pick(it, res);
			expected_picks = {expected_picks, res};
			req_taken = 1;
		end
	end

	always @(negedge clk) begin
		request_t it;
		if (arst_n && (!rq.valid || req_taken)) begin
			req_taken = 0;
			if (req_gap > 0) begin
				req_gap--;
				rq.valid <= 1'b0;
			end else if (pending_reqs.size() > 0) begin
				it = pending_reqs.pop_front();
				rq.req_type <= it.kind;
				rq.current_index <= it.row;
				rq.rand_choose <= it.choose;
				rq.rand_pick <= it.pick;
				rq.valid <= 1'b1;
				req_gap = no_gaps ? 0 : $urandom_range(0, 7);
			end else begin
				rq.valid <= 1'b0;
			end
		end
	end

	// Result monitor.
	always @(posedge clk) begin
		pick_t want;
		if (rs.valid && rs.ready) begin
			if (expected_picks.size() == 0) begin
				report_mismatch("unexpected result, index", rs.selected_index, -1);
			end else begin
				want = expected_picks.pop_front();
				if (rs.selected_index !== want.sel)
					report_mismatch("selected_index", rs.selected_index, want.sel);
				if (rs.explored !== want.expl)
					report_mismatch("explored", rs.explored, want.expl);
			end
		end
	end

	// Long receiver hold-off, counted down in its own process.
	always @(negedge clk) begin
		if (hold_cnt > 0) hold_cnt <= hold_cnt - 1;
	end

	always @(negedge clk) begin
		if (!arst_n || hold_cnt > 0) begin
			rs.ready <= 1'b0;
		end else if (rs.valid && rs.ready) begin
			rsp_gap = no_gaps ? 0 : $urandom_range(0, 7);
			rs.ready <= (rsp_gap == 0);
		end else if (rsp_gap > 0) begin
			rsp_gap--;
			rs.ready <= (rsp_gap == 0);
		end else begin
			rs.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	task automatic write_reg(input cfg_addr_t addr, input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cf.addr <= addr;
		cf.data <= data;
		cf.valid <= 1'b1;
		@(posedge clk);
		while (!cf.ready) @(posedge clk);
		if (addr == CFG_NUM_CHOICES) n_reg = data[4:0];
		else thr_reg = data;
		@(negedge clk);
		cf.valid <= 1'b0;
	endtask

	task automatic wait_idle();
		wait (pending_reqs.size() == 0 && expected_picks.size() == 0 && !rq.valid);
		repeat (10) @(posedge clk);
	endtask

	function automatic request_t make_req(input req_type_t k, input int row,
		input int choose, input int pick);
		return '{kind: k, row: 4'(row), choose: 16'(choose), pick: 16'(pick)};
	endfunction

	function automatic request_t random_req();
		request_t it;
		int roll, n;
		n = active_n();
		roll = $urandom_range(0, 99);
		if (roll < 88) it.kind = REQ_DRAW;
		else if (roll < 92) it.kind = REQ_UPDATE;
		else if (roll < 96) it.kind = REQ_CLEAR;
		else it.kind = REQ_NONE;
		it.row = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 15)) : 4'($urandom_range(0, n-1));
		it.choose = ($urandom_range(0, 15) == 0) ? thr_reg : 16'($urandom);
		it.pick = 16'($urandom);
		return it;
	endfunction

	initial begin
		int n, cnt;
		rq.valid = 1'b0;
		rq.req_type = REQ_NONE;
		rq.current_index = '0;
		rq.rand_choose = '0;
		rq.rand_pick = '0;
		rs.ready = 1'b0;
		cf.valid = 1'b0;
		cf.addr = CFG_NUM_CHOICES;
		cf.data = '0;
		n_reg = 5'd16;
		thr_reg = 16'd16384;
		restore_uniform();
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed items on the reset settings.
		add_req(make_req(REQ_DRAW, 0, 16384, 0));
		add_req(make_req(REQ_DRAW, 15, 16384, 65535));
		add_req(make_req(REQ_DRAW, 3, 16385, 0));
		add_req(make_req(REQ_DRAW, 15, 65535, 65535));
		add_req(make_req(REQ_DRAW, 7, 0, 4095));
		add_req(make_req(REQ_DRAW, 7, 65535, 4096));
		add_req(make_req(REQ_DRAW, 7, 65535, 61439));
		add_req(make_req(REQ_NONE, 15, 65535, 65535));
		add_req(make_req(REQ_UPDATE, 0, 0, 0));
		add_req(make_req(REQ_DRAW, 7, 65535, 30000));
		add_req(make_req(REQ_CLEAR, 0, 0, 0));
		wait_idle();
		// Fewer choices than rows: out-of-range rows, then a stale table until cleared.
		write_reg(CFG_NUM_CHOICES, 16'd3);
		write_reg(CFG_EXPLORE_THRESHOLD, 16'd0);
		add_req(make_req(REQ_DRAW, 3, 65535, 0));
		add_req(make_req(REQ_DRAW, 15, 0, 0));
		add_req(make_req(REQ_DRAW, 2, 65535, 20000));
		add_req(make_req(REQ_DRAW, 0, 0, 65535));
		add_req(make_req(REQ_CLEAR, 0, 0, 0));
		add_req(make_req(REQ_DRAW, 2, 1, 65535));
		add_req(make_req(REQ_DRAW, 2, 1, 43690));
		add_req(make_req(REQ_UPDATE, 0, 0, 0));
		add_req(make_req(REQ_DRAW, 1, 65535, 40000));
		wait_idle();

		for (int ph = 0; ph < 16; ph++) begin
			case (ph)
				0: n = 1;
				1: n = 16;
				2: n = 0;
				3: n = 31;
				4: n = 2;
				default: n = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 31)
					: $urandom_range(1, 6);
			endcase
			write_reg(CFG_NUM_CHOICES, 16'(n) | (16'($urandom) & 16'hFFE0));
			case (ph % 3)
				0: write_reg(CFG_EXPLORE_THRESHOLD, 16'd0);
				1: write_reg(CFG_EXPLORE_THRESHOLD, 16'd65535);
				default: write_reg(CFG_EXPLORE_THRESHOLD, 16'($urandom));
			endcase
			no_gaps = (ph % 4 == 3);
			if (ph == 5) hold_cnt = 400;
			if (ph % 2 == 0) add_req(make_req(REQ_CLEAR, 0, 0, 0));
			cnt = 0;
			while (cnt < 50) begin
				add_req(random_req());
				if (pending_reqs[$].kind != REQ_NONE) cnt++;
			end
			wait_idle();
		end
		repeat (50) @(posedge clk);
		if (errors == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end
endmodule
